// ----- rtl/rcd_pkg.sv -----
// ----------------------------------------------------------------------------
// rcd_pkg
// shared widths, limits, queue entry type and digit-to-ascii mapping for the
// radix conversion block
// ----------------------------------------------------------------------------
`default_nettype none

package rcd_pkg;

  // field widths
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned RadixWidth = 6;
  localparam int unsigned SizeWidth  = 7;
  localparam int unsigned CharWidth  = 7;
  localparam int unsigned DigitWidth = 6;

  // digit store
  localparam int unsigned MaxDigits     = 32;
  localparam int unsigned DigitIdxWidth = $clog2(MaxDigits);
  localparam int unsigned DigitCntWidth = $clog2(MaxDigits + 1);

  // divider: quotient bits resolved per cycle
  localparam int unsigned ChunkBits      = 8;
  localparam int unsigned ChunksPerDigit = ValueWidth / ChunkBits;
  localparam int unsigned ChunkCntWidth  = $clog2(ChunksPerDigit);

  // queue between front and back
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
  localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

  // radix limits
  localparam int unsigned RadixMin = 2;
  localparam int unsigned RadixMax = 36;

  // character codes
  localparam logic [CharWidth-1:0] AsciiZero   = 7'h30;
  localparam logic [CharWidth-1:0] AsciiUpperA = 7'h41;
  localparam int unsigned          DecimalBase = 10;

  // one classified item waiting for the divider
  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic [RadixWidth-1:0] radix;     // already saturated to 2..36
    logic [SizeWidth-1:0]  emit_max;  // buffer size minus one, or zero
  } job_t;

  function automatic logic [CharWidth-1:0] to_ascii(input logic [DigitWidth-1:0] digit);
    logic [CharWidth-1:0] d7;
    d7 = CharWidth'(digit);
    if (digit < DigitWidth'(DecimalBase)) begin
      return AsciiZero + d7;
    end
    return AsciiUpperA + (d7 - CharWidth'(DecimalBase));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rcd_in_if.sv -----
// ----------------------------------------------------------------------------
// rcd_in_if
// input channel: value, radix and buffer size with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface rcd_in_if import rcd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ValueWidth-1:0] value;
  logic [RadixWidth-1:0] radix;
  logic [SizeWidth-1:0]  buffer_size;

  modport source (output valid, output value, output radix, output buffer_size,
                  input ready);
  modport sink   (input valid, input value, input radix, input buffer_size,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/rcd_out_if.sv -----
// ----------------------------------------------------------------------------
// rcd_out_if
// output channel: one ascii digit and its last flag with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface rcd_out_if import rcd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] digit_char;
  logic                 last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

// ----- rtl/rcd_front.sv -----
// ----------------------------------------------------------------------------
// rcd_front
// accepts items, saturates the radix and works out the character limit
// ----------------------------------------------------------------------------
`default_nettype none

module rcd_front import rcd_pkg::*; (
  rcd_in_if.sink in_i,
  output logic   push_valid_o,
  input  logic   push_ready_i,
  output job_t   push_job_o
);

  logic [RadixWidth-1:0] radix_sat;
  logic [SizeWidth-1:0]  emit_max;

  always_comb begin
    if (in_i.radix < RadixWidth'(RadixMin)) begin
      radix_sat = RadixWidth'(RadixMin);
    end else if (in_i.radix > RadixWidth'(RadixMax)) begin
      radix_sat = RadixWidth'(RadixMax);
    end else begin
      radix_sat = in_i.radix;
    end
  end

  // one slot is kept for the terminator
  assign emit_max = (in_i.buffer_size < SizeWidth'(2)) ? '0
                                                       : in_i.buffer_size - SizeWidth'(1);

  assign push_valid_o        = in_i.valid;
  assign in_i.ready          = push_ready_i;
  assign push_job_o.value    = in_i.value;
  assign push_job_o.radix    = radix_sat;
  assign push_job_o.emit_max = emit_max;

endmodule

`default_nettype wire

// ----- rtl/rcd_queue.sv -----
// ----------------------------------------------------------------------------
// rcd_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module rcd_queue import rcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  job_t                     entry_q [QueueDepth];
  logic [QueuePtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntWidth-1:0] count_q, count_d;
  logic                     push, pop;

  assign push_ready_o = (count_q != QueueCntWidth'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_job_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrWidth'(QueueDepth - 1)) ? '0
                                                              : wr_ptr_q + QueuePtrWidth'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrWidth'(QueueDepth - 1)) ? '0
                                                              : rd_ptr_q + QueuePtrWidth'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QueueCntWidth'(1);
    end else if (pop && !push) begin
      count_d = count_q - QueueCntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rcd_back.sv -----
// ----------------------------------------------------------------------------
// rcd_back
// iterative divider filling the digit store, then most-significant-first
// emission through an output register
// ----------------------------------------------------------------------------
`default_nettype none

module rcd_back import rcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  job_t      job_i,
  rcd_out_if.source out_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [ValueWidth-1:0]    quot_q, quot_d;
  logic [DigitWidth-1:0]    rem_q, rem_d;
  logic [RadixWidth-1:0]    radix_q, radix_d;
  logic [SizeWidth-1:0]     emit_max_q, emit_max_d;
  logic [ChunkCntWidth-1:0] chunk_q, chunk_d;
  logic [DigitCntWidth-1:0] cnt_q, cnt_d;
  logic [DigitCntWidth-1:0] left_q, left_d;
  logic [DigitIdxWidth-1:0] idx_q, idx_d;
  logic                     out_valid_q, out_valid_d;
  logic [CharWidth-1:0]     out_char_q, out_char_d;
  logic                     out_last_q, out_last_d;

  logic [DigitWidth-1:0]    digit_q [MaxDigits];

  logic [ValueWidth-1:0]    quot_w;
  logic [DigitWidth-1:0]    rem_w;
  logic                     digit_done;
  logic [DigitCntWidth-1:0] cnt_next;
  logic [DigitCntWidth-1:0] emit_n;
  logic                     out_free;

  // one chunk of restoring division by the radix
  always_comb begin
    logic [DigitWidth:0] trial;
    rem_w  = rem_q;
    quot_w = quot_q;
    for (int i = 0; i < ChunkBits; i++) begin
      trial  = {rem_w, quot_w[ValueWidth-1]};
      quot_w = {quot_w[ValueWidth-2:0], 1'b0};
      if (trial >= {1'b0, radix_q}) begin
        rem_w     = DigitWidth'(trial - {1'b0, radix_q});
        quot_w[0] = 1'b1;
      end else begin
        rem_w = trial[DigitWidth-1:0];
      end
    end
  end

  assign digit_done = (chunk_q == ChunkCntWidth'(ChunksPerDigit - 1));
  assign cnt_next   = cnt_q + DigitCntWidth'(1);
  assign emit_n     = (SizeWidth'(cnt_next) > emit_max_q) ? emit_max_q[DigitCntWidth-1:0]
                                                          : cnt_next;
  assign out_free   = !out_valid_q || out_o.ready;
  assign job_ready_o = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    radix_d     = radix_q;
    emit_max_d  = emit_max_q;
    chunk_d     = chunk_q;
    cnt_d       = cnt_q;
    left_d      = left_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          quot_d     = job_i.value;
          radix_d    = job_i.radix;
          emit_max_d = job_i.emit_max;
          rem_d      = '0;
          chunk_d    = '0;
          cnt_d      = '0;
          state_d    = StDiv;
        end
      end
      StDiv: begin
        quot_d  = quot_w;
        rem_d   = rem_w;
        chunk_d = chunk_q + ChunkCntWidth'(1);
        if (digit_done) begin
          chunk_d = '0;
          rem_d   = '0;
          cnt_d   = cnt_next;
          if (quot_w == '0 || cnt_next == DigitCntWidth'(MaxDigits)) begin
            left_d  = emit_n;
            idx_d   = cnt_q[DigitIdxWidth-1:0];
            state_d = (emit_n == '0) ? StIdle : StEmit;
          end
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = to_ascii(digit_q[idx_q]);
          out_last_d  = (left_q == DigitCntWidth'(1));
          left_d      = left_q - DigitCntWidth'(1);
          idx_d       = idx_q - DigitIdxWidth'(1);
          if (left_q == DigitCntWidth'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      chunk_q     <= '0;
      cnt_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chunk_q     <= chunk_d;
      cnt_q       <= cnt_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q     <= quot_d;
    rem_q      <= rem_d;
    radix_q    <= radix_d;
    emit_max_q <= emit_max_d;
    idx_q      <= idx_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    if (state_q == StDiv && digit_done) begin
      digit_q[cnt_q[DigitIdxWidth-1:0]] <= rem_w;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.digit_char = out_char_q;
  assign out_o.last_digit = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/radix_convert_by_division.sv -----
// ----------------------------------------------------------------------------
// radix_convert_by_division
// converts an unsigned value to ascii digits in radix 2..36, most significant
// digit first, with the character count limited by the buffer size
// ----------------------------------------------------------------------------
// the divider resolves 8 quotient bits a cycle and finishes all digits of an
//   item before its first character is loaded into the output register
// the single divider and the digit store serve one item at a time, so the back
//   takes no new item from the queue until it is done with the current one
// the two-entry queue lets the input take items while the divider is busy
// reset: queue, sequencer and output valid clear; the digit store is not cleared
`default_nettype none

module radix_convert_by_division import rcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rcd_in_if.sink    in_i,
  rcd_out_if.source out_o
);

  // classified item from the front towards the queue
  logic push_valid;
  logic push_ready;
  job_t push_job;

  // queue head towards the divider
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  // front: radix saturation and character limit, no storage
  rcd_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  // decoupling queue, lets the input side run ahead of the divider
  rcd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // back: repeated division into the digit store, then emission
  rcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
